/* src/deq_pkg.sv */
// deq_pkg: action and error codes shared by the deque block
// no dependencies; imported by double_ended_queue
`default_nettype none

package deq_pkg;

    // action carried by each input transaction
    typedef enum logic [1:0] {
        ACT_IDLE   = 2'd0,
        ACT_PUSH_R = 2'd1,
        ACT_POP_L  = 2'd2,
        ACT_POP_R  = 2'd3
    } action_t;

    // error code reported with each result
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

endpackage

`default_nettype wire

/* src/double_ended_queue.sv */
// double_ended_queue: bounded deque with right push and pops at both ends
// words live in a circular single-port-style memory; depends on deq_pkg
`default_nettype none

// channel   direction  handshake            payload
// input     in         in_valid / in_stall  action, value
// output    out        out_valid / out_stall popped, popped_valid, left_word,
//                                           right_word, empty_res, count, error
//
// an item is decoded and the deque updated, then transferred into the output register
// a pop that leaves two or more words passes through the read state: the new end word
// is read from the slot memory, whose read data is registered
// the end words are cached in registers, so pushes and other pops need no read
// reset clears pointers, count, cached ends and outputs; the slot memory is not cleared
// a result waiting under out_stall lets the next input transaction in, which then
// waits in its hold cycle until the output register frees

module double_ended_queue #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  deq_pkg::action_t             action,
    input  wire  [WORD_BITS-1:0]         value,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [WORD_BITS-1:0]         popped,
    output logic                         popped_valid,
    output logic [WORD_BITS-1:0]         left_word,
    output logic [WORD_BITS-1:0]         right_word,
    output logic                         empty_res,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output deq_pkg::err_t                error
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } state_t;

    // slot memory
    logic [WORD_BITS-1:0] slots [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // control and cached state
    state_t               state_reg;
    logic [AW-1:0]        lpos_reg;
    logic [CW-1:0]        held_reg;
    logic [WORD_BITS-1:0] left_reg;
    logic [WORD_BITS-1:0] right_reg;
    logic                 side_reg;

    // pending result of the current item
    logic [WORD_BITS-1:0] pend_popped_reg;
    logic                 pend_pv_reg;
    err_t                 pend_err_reg;

    // output registers
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] popped_reg;
    logic                 popped_valid_reg;
    logic [WORD_BITS-1:0] left_word_reg;
    logic [WORD_BITS-1:0] right_word_reg;
    logic                 empty_reg;
    logic [CW-1:0]        count_reg;
    err_t                 error_reg;

    // decode and address arithmetic
    logic          accept;
    logic          is_pop;
    logic          is_full;
    logic          is_empty;
    logic [AW:0]   held_ext;
    logic [AW:0]   wr_sum;
    logic [AW:0]   inc_sum;
    logic [AW:0]   rr_sum;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] lpos_inc;
    logic [AW-1:0] rr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          rd_en;

    always_comb
    begin
        accept   = in_valid && (state_reg == S_IDLE);
        is_pop   = (action == ACT_POP_L) || (action == ACT_POP_R);
        is_full  = (held_reg >= CW'(DEPTH));
        is_empty = (held_reg == '0);
        held_ext = (AW+1)'(held_reg);

        // slot just right of the rightmost word
        wr_sum  = {1'b0, lpos_reg} + held_ext;
        wr_addr = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH)) : AW'(wr_sum);

        // slot right of the leftmost word
        inc_sum  = {1'b0, lpos_reg} + (AW+1)'(1);
        lpos_inc = (inc_sum >= (AW+1)'(DEPTH)) ? AW'(inc_sum - (AW+1)'(DEPTH))
                                                : AW'(inc_sum);

        // slot left of the rightmost word (used only when three or more held)
        rr_sum  = {1'b0, lpos_reg} + held_ext - (AW+1)'(2);
        rr_addr = (rr_sum >= (AW+1)'(DEPTH)) ? AW'(rr_sum - (AW+1)'(DEPTH)) : AW'(rr_sum);

        wr_en   = accept && (action == ACT_PUSH_R) && !is_full;
        rd_en   = accept && is_pop && (held_reg >= CW'(3));
        rd_addr = (action == ACT_POP_L) ? lpos_inc : rr_addr;
    end

    // slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= slots[rd_addr];
        end
    end

    // sequencer, deque state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            lpos_reg         <= '0;
            held_reg         <= '0;
            left_reg         <= '0;
            right_reg        <= '0;
            side_reg         <= 1'b0;
            pend_popped_reg  <= '0;
            pend_pv_reg      <= 1'b0;
            pend_err_reg     <= ERR_NONE;
            out_valid_reg    <= 1'b0;
            popped_reg       <= '0;
            popped_valid_reg <= 1'b0;
            left_word_reg    <= '0;
            right_word_reg   <= '0;
            empty_reg        <= 1'b1;
            count_reg        <= '0;
            error_reg        <= ERR_NONE;
        end
        else
        begin
            // output transaction taken with no new result loading
            if (out_valid_reg && !out_stall && (state_reg != S_HOLD))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (action)
                            ACT_PUSH_R:
                            begin
                                pend_popped_reg <= '0;
                                pend_pv_reg     <= 1'b0;
                                state_reg       <= S_HOLD;
                                if (is_full)
                                begin
                                    pend_err_reg <= ERR_FULL;
                                end
                                else
                                begin
                                    pend_err_reg <= ERR_NONE;
                                    held_reg     <= held_reg + CW'(1);
                                    right_reg    <= value;
                                    if (is_empty)
                                    begin
                                        left_reg <= value;
                                    end
                                end
                            end
                            ACT_POP_L,
                            ACT_POP_R:
                            begin
                                if (is_empty)
                                begin
                                    pend_popped_reg <= '0;
                                    pend_pv_reg     <= 1'b0;
                                    pend_err_reg    <= ERR_EMPTY;
                                    state_reg       <= S_HOLD;
                                end
                                else
                                begin
                                    pend_err_reg    <= ERR_NONE;
                                    pend_pv_reg     <= 1'b1;
                                    pend_popped_reg <= (action == ACT_POP_L) ? left_reg
                                                                             : right_reg;
                                    held_reg        <= held_reg - CW'(1);
                                    if (action == ACT_POP_L)
                                    begin
                                        lpos_reg <= lpos_inc;
                                    end
                                    // two held: the other cached end becomes both ends
                                    if (held_reg == CW'(2))
                                    begin
                                        if (action == ACT_POP_L)
                                        begin
                                            left_reg <= right_reg;
                                        end
                                        else
                                        begin
                                            right_reg <= left_reg;
                                        end
                                    end
                                    // three or more held: fetch the new end word
                                    if (held_reg >= CW'(3))
                                    begin
                                        side_reg  <= (action == ACT_POP_L);
                                        state_reg <= S_READ;
                                    end
                                    else
                                    begin
                                        state_reg <= S_HOLD;
                                    end
                                end
                            end
                            default:
                            begin
                                pend_popped_reg <= '0;
                                pend_pv_reg     <= 1'b0;
                                pend_err_reg    <= ERR_NONE;
                                state_reg       <= S_HOLD;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    // refresh the cached end from memory read data
                    if (side_reg)
                    begin
                        left_reg <= rd_data_reg;
                    end
                    else
                    begin
                        right_reg <= rd_data_reg;
                    end
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    // load the output register once it is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        popped_reg       <= pend_popped_reg;
                        popped_valid_reg <= pend_pv_reg;
                        left_word_reg    <= is_empty ? '0 : left_reg;
                        right_word_reg   <= is_empty ? '0 : right_reg;
                        empty_reg        <= is_empty;
                        count_reg        <= held_reg;
                        error_reg        <= pend_err_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // port drive
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign popped       = popped_reg;
    assign popped_valid = popped_valid_reg;
    assign left_word    = left_word_reg;
    assign right_word   = right_word_reg;
    assign empty_res    = empty_reg;
    assign count        = count_reg;
    assign error        = error_reg;

    // count never exceeds the store depth
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(DEPTH))
        else $error("held count exceeds depth");

    // empty flag agrees with the reported count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_res == (count == '0)))
        else $error("empty flag disagrees with count");

    // a successful pop never carries an error
    a_pop_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && popped_valid) |-> (error == ERR_NONE))
        else $error("pop reported with error");

    // an accepted item keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

endmodule

`default_nettype wire
